### hw/rtl/ordered_list_table_assert.svh
// Assertion macros used by the ordered list table sequencer, olt_seq.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ORDERED_LIST_TABLE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, checked at every clock outside reset.
`define OLT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_list_table assertion failed");

// Next-cycle implication, checked at every clock outside reset.
`define OLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_list_table assertion failed");

`endif

### hw/rtl/olt_pkg.sv
// Package for the ordered list table: request and status codes, result type.
// Used by all the RTL modules and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package olt_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_POS_BIG   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [4:0] count;
        logic       found;
        logic [1:0] status;
    } olt_result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } olt_mem_cmd_t;

endpackage

### hw/rtl/olt_mem.sv
// Entry store of the ordered list table: one write port, one read port.
// Synchronous, registered read; depends on olt_pkg.
`timescale 1ns / 1ps

module olt_mem
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  olt_mem_cmd_t  cmd,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/olt_seq.sv
// Request sequencer of the ordered list table: scans the entry store for a match,
// then shifts entries up or down one per cycle. Depends on olt_pkg and the macro header.
`timescale 1ns / 1ps
`include "ordered_list_table_assert.svh"

module olt_seq
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [1:0]    req_mode,
    input  logic [4:0]    req_position,
    input  logic [31:0]   req_value,
    output logic          res_valid,
    input  logic          res_ready,
    output olt_result_t   res,
    output olt_mem_cmd_t  mem_cmd,
    output logic [AW-1:0] mem_waddr,
    output logic [31:0]   mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [31:0]   mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_UP   = 3'd3;
    localparam logic [2:0] S_DOWN = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] ins_reg, ins_next;
    logic [1:0]    status_reg, status_next;
    logic          found_reg, found_next;
    logic [1:0]    mode_reg;
    logic [4:0]    pos_reg;
    logic [31:0]   value_reg;

    logic [CW-1:0] count_m1;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] count_w;
    logic          full;
    logic [CW-1:0] wr_ptr;
    logic [CW-1:0] rd_ptr;

    assign count_m1 = count_reg - CW'(1);
    assign pos_w    = PW'(pos_reg);
    assign count_w  = PW'(count_reg);
    assign full     = (count_reg >= CW'(DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        ins_next    = ins_reg;
        status_next = status_reg;
        found_next  = found_reg;
        mem_cmd     = '0;
        wr_ptr      = ptr_reg;
        rd_ptr      = ptr_reg;
        mem_wdata   = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    found_next = 1'b0;
                    ptr_next   = '0;
                    if (count_reg != '0)
                    begin
                        mem_cmd.rd_en = 1'b1;
                        rd_ptr        = '0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_SCAN:
            begin
                if (mem_rdata == value_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_EVAL;
                end
                else if (ptr_reg == count_m1)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    mem_cmd.rd_en = 1'b1;
                    rd_ptr        = ptr_reg + CW'(1);
                    ptr_next      = ptr_reg + CW'(1);
                end
            end
            S_EVAL:
            begin
                status_next = ST_OK;
                state_next  = S_DONE;
                case (mode_reg)
                    MODE_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ins_next   = count_reg;
                            state_next = S_PUT;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (pos_w > count_w)
                        begin
                            status_next = ST_POS_BIG;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ins_next = pos_w[CW-1:0];
                            if (pos_w[CW-1:0] == count_reg)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                mem_cmd.rd_en = 1'b1;
                                rd_ptr        = count_m1;
                                ptr_next      = count_m1;
                                state_next    = S_UP;
                            end
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (ptr_reg == count_m1)
                        begin
                            count_next = count_m1;
                        end
                        else
                        begin
                            mem_cmd.rd_en = 1'b1;
                            rd_ptr        = ptr_reg + CW'(1);
                            ptr_next      = ptr_reg + CW'(1);
                            state_next    = S_DOWN;
                        end
                    end
                    default:
                    begin
                        status_next = found_reg ? ST_OK : ST_NOT_FOUND;
                    end
                endcase
            end
            S_UP:
            begin
                mem_cmd.wr_en = 1'b1;
                wr_ptr        = ptr_reg + CW'(1);
                if (ptr_reg == ins_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_cmd.rd_en = 1'b1;
                    rd_ptr        = ptr_reg - CW'(1);
                    ptr_next      = ptr_reg - CW'(1);
                end
            end
            S_DOWN:
            begin
                mem_cmd.wr_en = 1'b1;
                wr_ptr        = ptr_reg - CW'(1);
                if (ptr_reg == count_m1)
                begin
                    count_next = count_m1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_cmd.rd_en = 1'b1;
                    rd_ptr        = ptr_reg + CW'(1);
                    ptr_next      = ptr_reg + CW'(1);
                end
            end
            S_PUT:
            begin
                mem_cmd.wr_en = 1'b1;
                wr_ptr        = ins_reg;
                mem_wdata     = value_reg;
                count_next    = count_reg + CW'(1);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_waddr = wr_ptr[AW-1:0];
    assign mem_raddr = rd_ptr[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        if (req_valid && req_ready)
        begin
            mode_reg  <= req_mode;
            pos_reg   <= req_position;
            value_reg <= req_value;
        end
    end

    assign req_ready    = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res.status   = status_reg;
    assign res.found    = found_reg;
    assign res.count    = count_w[4:0];

    `OLT_ASSERT_NOW(a_no_same_slot, mem_cmd.wr_en && mem_cmd.rd_en, mem_waddr != mem_raddr)
    `OLT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `OLT_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN, ptr_reg < count_reg)
    `OLT_ASSERT_NOW(a_write_phase, mem_cmd.wr_en,
        state_reg == S_UP || state_reg == S_DOWN || state_reg == S_PUT)
    `OLT_ASSERT_NEXT(a_put_grows, state_reg == S_PUT, count_reg == $past(count_reg) + CW'(1))

endmodule

### hw/rtl/ordered_list_table.sv
// Top level of the ordered list table: sequencer, entry store and output register.
// Depends on olt_pkg, olt_seq and olt_mem.
`timescale 1ns / 1ps
//
//  Channel   Direction  Bits  Contents
//  s_axis    in         40    mode, position, value (one request word)
//  m_axis    out        8     status, found, count (one result word)
//
//  A request runs from acceptance to m_axis_tvalid through the search, which reads entries
//  up to the first match, else all stored entries, then an evaluation step, the moves of
//  entries, the store of the value when one is stored, the result state and the output
//  register; the entry store's single read and single write port make the search and the
//  moves handle one entry at a time. The next request is accepted in the cycle after the
//  result leaves the sequencer. Reset clears the count; the store is not cleared and needs
//  no clearing pass. A finished result waits in the output register, so a stall on m_axis
//  holds off only the request after the one that is already accepted.

module ordered_list_table
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // mode[1:0], position[6:2], value[38:7], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[1:0], found[2], count[7:3]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          res_valid;
    logic          res_ready;
    olt_result_t   res;
    olt_mem_cmd_t  mem_cmd;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    logic          out_valid_reg;
    olt_result_t   out_reg;

    olt_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_axis_tvalid),
        .req_ready    (s_axis_tready),
        .req_mode     (s_axis_tdata[1:0]),
        .req_position (s_axis_tdata[6:2]),
        .req_value    (s_axis_tdata[38:7]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_cmd      (mem_cmd),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    olt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.count, out_reg.found, out_reg.status};

endmodule

### sim/ordered_list_table_tb.sv
// Self-checking testbench for ordered_list_table: directed and random append, insert,
// delete and query words against a scoreboard that keeps its own copy of the list.
// Depends on olt_pkg and the ordered_list_table RTL only.
`timescale 1ns / 1ps

module ordered_list_table_tb;
    import olt_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    class list_scoreboard;
        logic signed [31:0] slots [DEPTH];
        int unsigned fill;
        olt_result_t expected_q [$];
        int unsigned mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function void shift_in(int unsigned at, logic signed [31:0] value);
            for (int i = fill; i > at; i--)
                slots[i] = slots[i - 1];
            slots[at] = value;
            fill++;
        endfunction

        function void note_request(logic [1:0] mode, logic [4:0] position,
                                   logic signed [31:0] value);
            olt_result_t res;
            int unsigned hit;
            hit = fill;
            for (int i = 0; i < fill; i++)
            begin
                if (slots[i] == value)
                begin
                    hit = i;
                    break;
                end
            end
            res.found = (hit < fill);
            res.status = ST_OK;
            case (mode)
                MODE_APPEND:
                begin
                    if (fill >= DEPTH)
                        res.status = ST_FULL;
                    else
                        shift_in(fill, value);
                end
                MODE_INSERT:
                begin
                    if (position > fill)
                        res.status = ST_POS_BIG;
                    else if (fill >= DEPTH)
                        res.status = ST_FULL;
                    else
                        shift_in(position, value);
                end
                MODE_DELETE:
                begin
                    if (res.found)
                    begin
                        for (int i = hit; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                    else
                        res.status = ST_NOT_FOUND;
                end
                default:
                    res.status = res.found ? ST_OK : ST_NOT_FOUND;
            endcase
            res.count = fill[4:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] word);
            olt_result_t got;
            olt_result_t exp;
            got = olt_result_t'(word);
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, word);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp.status, got.status);
                mismatches++;
            end
            if (got.found !== exp.found)
            begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, exp.found, got.found);
                mismatches++;
            end
            if (got.count !== exp.count)
            begin
                $display("%0t: count mismatch, expected %0d, actual %0d",
                         $time, exp.count, got.count);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // mode[1:0], position[6:2], value[38:7], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // status[1:0], found[2], count[7:3]

    list_scoreboard sb;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;

    ordered_list_table #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(logic [1:0] mode, logic [4:0] position, logic [31:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, value, position, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(mode, position, value);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] pool [8];
        int unsigned r;
        pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002};
        r = $urandom_range(99);
        if (r < 35 && sb.fill > 0)
            return sb.slots[$urandom_range(sb.fill - 1)];
        else if (r < 70)
            return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic random_request(bit growing);
        int unsigned r;
        logic [1:0] mode;
        logic [4:0] position;
        r = $urandom_range(99);
        if (growing)
            mode = (r < 40) ? MODE_APPEND : (r < 80) ? MODE_INSERT :
                   (r < 90) ? MODE_DELETE : MODE_QUERY;
        else
            mode = (r < 10) ? MODE_APPEND : (r < 20) ? MODE_INSERT :
                   (r < 80) ? MODE_DELETE : MODE_QUERY;
        if ($urandom_range(99) < 85)
            position = 5'($urandom_range(sb.fill));
        else
            position = 5'($urandom_range(16));
        send_request(mode, position, pick_value());
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(MODE_QUERY, 5'd0, 32'd123);
        send_request(MODE_DELETE, 5'd0, 32'd123);
        send_request(MODE_INSERT, 5'd1, 32'd9);
        send_request(MODE_INSERT, 5'd0, 32'h8000_0000);
        send_request(MODE_APPEND, 5'd31, 32'h7FFF_FFFF);
        send_request(MODE_APPEND, 5'd0, 32'h0000_0000);
        send_request(MODE_APPEND, 5'd0, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 5'd16, 32'd4);
        send_request(MODE_INSERT, 5'd2, 32'd5);
        send_request(MODE_INSERT, 5'd5, 32'd7);
        send_request(MODE_APPEND, 5'd0, 32'h0000_0000);
        send_request(MODE_QUERY, 5'd0, 32'h0000_0000);
        send_request(MODE_QUERY, 5'd0, 32'd123);
        send_request(MODE_DELETE, 5'd0, 32'h0000_0000);
        while (sb.fill < DEPTH)
            send_request(MODE_APPEND, 5'd0, $urandom);
        send_request(MODE_APPEND, 5'd0, 32'd77);
        send_request(MODE_INSERT, 5'd16, 32'd78);
        send_request(MODE_INSERT, 5'd0, 32'd79);
        send_request(MODE_DELETE, 5'd15, 32'h7FFF_FFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            for (int n = 0; n < 250; n++)
                random_request(((n / 40) % 2) == 0);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/olt_pkg.sv
hw/rtl/olt_mem.sv
hw/rtl/olt_seq.sv
hw/rtl/ordered_list_table.sv
sim/ordered_list_table_tb.sv
